@@ rtl/core/pwdf_pkg.sv @@
// Shared types, constants and helpers for the priority weighted drop FIFO.
package pwdf_pkg;

    localparam int MAX_SIZE_W = 11;
    localparam int LEVEL_W    = 8;
    localparam int PRIO_W     = 8;
    localparam int HANDLE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int CFG_IDX_W  = 1;

    localparam int DEPTH_DEFAULT       = 1024;
    localparam int HANDLE_BITS_DEFAULT = 16;

    localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = 11'd1024;
    localparam logic [LEVEL_W-1:0]    LEVEL_RESET    = 8'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SIZE = 1'b0,
        CFG_LEVEL    = 1'b1
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_DEQUEUED = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_ENQ_CHK,
        FSM_DEQ_MUL,
        FSM_DEQ_CHK,
        FSM_DONE
    } fsm_t;

    // Admission operands handed to the compare unit.
    typedef struct packed {
        logic [MAX_SIZE_W-1:0] max_size;
        logic [LEVEL_W-1:0]    level;
        logic [PRIO_W-1:0]     prio;
    } admit_cfg_t;

    function automatic logic [COUNT_W-1:0] sat_count(input logic [31:0] v);
        logic [31:0] lim;
        lim = 32'((1 << COUNT_W) - 1);
        return (v > lim) ? lim[COUNT_W-1:0] : v[COUNT_W-1:0];
    endfunction

endpackage

@@ rtl/core/pwdf_if.sv @@
// Request and response channel interfaces.
interface pwdf_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [pwdf_pkg::HANDLE_W-1:0] packet_handle;
    logic [pwdf_pkg::PRIO_W-1:0]   priority_req;

    modport source (output valid, op, packet_handle, priority_req, input ready);
    modport sink   (input valid, op, packet_handle, priority_req, output ready);
endinterface

interface pwdf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pwdf_pkg::STATUS_W-1:0] status;
    logic [pwdf_pkg::HANDLE_W-1:0] out_handle;
    logic [pwdf_pkg::PRIO_W-1:0]   out_priority;
    logic [pwdf_pkg::COUNT_W-1:0]  discarded;
    logic [pwdf_pkg::COUNT_W-1:0]  occupancy;

    modport source (output valid, status, out_handle, out_priority, discarded, occupancy,
                    input ready);
    modport sink   (input valid, status, out_handle, out_priority, discarded, occupancy,
                    output ready);
endinterface

@@ rtl/core/priority_weighted_drop_fifo.sv @@
// Top level: the packet FIFO with priority weighted admission and head discard.
// Enqueue: accept (IDLE), compare and slot write (ENQ_CHK), result (DONE).
// Dequeue: each popped packet passes DEQ_MUL then DEQ_CHK; each pop costs a slot read and a
// registered multiply before its threshold compare. An empty dequeue goes from IDLE to DONE.
// One item at a time; the next is accepted while the previous result still waits.
// rst_n clears pointers, counts, state, config, status and valid; slots and data stay undefined.
module priority_weighted_drop_fifo #(
    parameter int DEPTH       = pwdf_pkg::DEPTH_DEFAULT,
    parameter int HANDLE_BITS = pwdf_pkg::HANDLE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pwdf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pwdf_pkg::MAX_SIZE_W-1:0]  cfg_data,
    pwdf_req_if.sink                         req,
    pwdf_rsp_if.source                       rsp
);
    localparam int HW    = (HANDLE_BITS >= pwdf_pkg::HANDLE_W) ? pwdf_pkg::HANDLE_W
                                                               : HANDLE_BITS;
    localparam int EW    = HW + pwdf_pkg::PRIO_W;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FCW   = $clog2(DEPTH + 1);
    localparam int CNT_W = FCW + 1;

    // configuration
    logic [pwdf_pkg::MAX_SIZE_W-1:0] max_size_reg;
    logic [pwdf_pkg::LEVEL_W-1:0]    level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= pwdf_pkg::MAX_SIZE_RESET;
            level_reg    <= pwdf_pkg::LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (pwdf_pkg::cfg_idx_t'(cfg_index))
                pwdf_pkg::CFG_MAX_SIZE: max_size_reg <= cfg_data;
                pwdf_pkg::CFG_LEVEL:    level_reg    <= cfg_data[pwdf_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // state
    pwdf_pkg::fsm_t state_reg, state_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  tail_reg, tail_next;
    logic [FCW-1:0] fill_reg, fill_next;
    logic [FCW-1:0] disc_reg, disc_next;
    pwdf_pkg::status_t res_status_reg, res_status_next;
    logic [HW-1:0]  res_handle_reg, res_handle_next;
    logic [pwdf_pkg::PRIO_W-1:0] res_prio_reg, res_prio_next;
    logic [HW-1:0]  hold_handle_reg;
    logic [pwdf_pkg::PRIO_W-1:0] hold_prio_reg;

    // slot memory, one read port at the head, one write port at the tail
    logic [EW-1:0]  slot_mem [DEPTH];
    logic [EW-1:0]  rdata_reg;
    logic           mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[tail_reg] <= {hold_prio_reg, hold_handle_reg};
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= slot_mem[head_reg];
    end

    logic [pwdf_pkg::PRIO_W-1:0] rd_prio;
    logic [HW-1:0]               rd_handle;
    assign rd_prio   = rdata_reg[EW-1:HW];
    assign rd_handle = rdata_reg[HW-1:0];

    // admission compare
    logic                  in_beat, out_load, drop;
    logic [CNT_W-1:0]      admit_cnt;
    pwdf_pkg::admit_cfg_t  admit_cfg;
    logic                  full;

    assign in_beat = req.valid && req.ready;
    assign full    = (fill_reg == FCW'(DEPTH));

    always_comb
    begin
        admit_cfg.max_size = max_size_reg;
        admit_cfg.level    = level_reg;
        if (state_reg == pwdf_pkg::FSM_IDLE)
        begin
            admit_cnt      = CNT_W'(fill_reg) + CNT_W'(1);
            admit_cfg.prio = req.priority_req;
        end
        else
        begin
            // occupancy left after the pop, plus one
            admit_cnt      = CNT_W'(fill_reg);
            admit_cfg.prio = rd_prio;
        end
    end

    pwdf_admit #(
        .CNT_W (CNT_W)
    ) u_admit (
        .clk  (clk),
        .cnt  (admit_cnt),
        .acfg (admit_cfg),
        .drop (drop)
    );

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pwdf_pkg::FSM_IDLE:
            begin
                if (in_beat)
                begin
                    if (!req.op)
                        state_next = pwdf_pkg::FSM_ENQ_CHK;
                    else if (fill_reg == '0)
                        state_next = pwdf_pkg::FSM_DONE;
                    else
                        state_next = pwdf_pkg::FSM_DEQ_MUL;
                end
            end
            pwdf_pkg::FSM_ENQ_CHK: state_next = pwdf_pkg::FSM_DONE;
            pwdf_pkg::FSM_DEQ_MUL: state_next = pwdf_pkg::FSM_DEQ_CHK;
            pwdf_pkg::FSM_DEQ_CHK:
            begin
                if (drop && fill_reg != '0)
                    state_next = pwdf_pkg::FSM_DEQ_MUL;
                else
                    state_next = pwdf_pkg::FSM_DONE;
            end
            pwdf_pkg::FSM_DONE:
            begin
                if (out_load)
                    state_next = pwdf_pkg::FSM_IDLE;
            end
            default: state_next = pwdf_pkg::FSM_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        req.ready = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        unique case (state_reg)
            pwdf_pkg::FSM_IDLE:    req.ready = 1'b1;
            pwdf_pkg::FSM_ENQ_CHK: mem_we    = !drop && !full;
            pwdf_pkg::FSM_DONE:    out_load  = !rsp.valid || rsp.ready;
            default: ;
        endcase
    end

    // datapath updates
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        disc_next       = disc_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_prio_next   = res_prio_reg;
        case (state_reg)
            pwdf_pkg::FSM_IDLE:
            begin
                disc_next       = '0;
                res_handle_next = '0;
                res_prio_next   = '0;
                res_status_next = pwdf_pkg::ST_EMPTY;
            end
            pwdf_pkg::FSM_ENQ_CHK:
            begin
                if (mem_we)
                begin
                    tail_next       = ptr_inc(tail_reg);
                    fill_next       = fill_reg + FCW'(1);
                    res_status_next = pwdf_pkg::ST_ENQUEUED;
                end
                else
                    res_status_next = pwdf_pkg::ST_DROPPED;
            end
            pwdf_pkg::FSM_DEQ_MUL:
            begin
                head_next = ptr_inc(head_reg);
                fill_next = fill_reg - FCW'(1);
            end
            pwdf_pkg::FSM_DEQ_CHK:
            begin
                if (drop)
                    disc_next = disc_reg + FCW'(1);
                else
                begin
                    res_status_next = pwdf_pkg::ST_DEQUEUED;
                    res_handle_next = rd_handle;
                    res_prio_next   = rd_prio;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pwdf_pkg::FSM_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            disc_reg       <= '0;
            res_status_reg <= pwdf_pkg::ST_EMPTY;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            disc_reg       <= disc_next;
            res_status_reg <= res_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_handle_reg <= res_handle_next;
        res_prio_reg   <= res_prio_next;
        if (in_beat)
        begin
            hold_handle_reg <= req.packet_handle[HW-1:0];
            hold_prio_reg   <= req.priority_req;
        end
    end

    // output register
    logic                          out_valid_reg;
    pwdf_pkg::status_t             out_status_reg;
    logic [HW-1:0]                 out_handle_reg;
    logic [pwdf_pkg::PRIO_W-1:0]   out_prio_reg;
    logic [pwdf_pkg::COUNT_W-1:0]  out_disc_reg;
    logic [pwdf_pkg::COUNT_W-1:0]  out_occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_prio_reg   <= res_prio_reg;
            out_disc_reg   <= pwdf_pkg::sat_count(32'(disc_reg));
            out_occ_reg    <= pwdf_pkg::sat_count(32'(fill_reg));
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_handle   = pwdf_pkg::HANDLE_W'(out_handle_reg);
    assign rsp.out_priority = out_prio_reg;
    assign rsp.discarded    = out_disc_reg;
    assign rsp.occupancy    = out_occ_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FCW'(DEPTH))
        else $error("fill count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with split pointers");

    a_enq_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == pwdf_pkg::ST_ENQUEUED |-> rsp.occupancy != '0)
        else $error("enqueue reported with zero occupancy");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != pwdf_pkg::FSM_IDLE |-> !req.ready)
        else $error("request taken while busy");

    a_write_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> tail_reg != $past(tail_reg) || DEPTH == 1)
        else $error("tail did not advance after a slot write");
`endif
endmodule

@@ rtl/core/pwdf_admit.sv @@
// Registered threshold compare: drop when level is zero, prio > level, or cnt*level > max_size*(level-prio).
module pwdf_admit #(
    parameter int CNT_W = 12
) (
    input  logic                clk,
    input  logic [CNT_W-1:0]    cnt,
    input  pwdf_pkg::admit_cfg_t acfg,
    output logic                drop
);
    localparam int AW   = CNT_W + pwdf_pkg::LEVEL_W;
    localparam int BW   = pwdf_pkg::MAX_SIZE_W + pwdf_pkg::LEVEL_W;
    localparam int CMPW = (AW > BW) ? AW : BW;

    logic [AW-1:0] load_reg;
    logic [BW-1:0] lim_reg;
    logic          zero_thr_reg;
    logic [pwdf_pkg::LEVEL_W-1:0] headroom;

    assign headroom = acfg.level - acfg.prio;

    // floor() drops out: n > floor(x) holds exactly when n > x for integer n
    always_ff @(posedge clk)
    begin
        load_reg     <= AW'(cnt) * AW'(acfg.level);
        lim_reg      <= BW'(acfg.max_size) * BW'(headroom);
        zero_thr_reg <= (acfg.level == '0) || (acfg.prio > acfg.level);
    end

    assign drop = zero_thr_reg || (CMPW'(load_reg) > CMPW'(lim_reg));
endmodule
